@@ design/sha_pkg.sv @@
// sha_pkg: shared types and constants of the sha-256 stream hasher
// round constants, initial values and round helper functions; no dependencies
`timescale 1ns / 1ps
package sha_pkg;

   localparam int QDepth = 4;
   localparam int QAw = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       is_last;
   } req_item_type;

   typedef logic [31:0] word_type;

   localparam logic [255:0] IV256 = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [255:0] IV224 = {
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

   function automatic word_type iv_word(input logic m224, input logic [2:0] i);
      logic [255:0] v;
      v = m224 ? IV224 : IV256;
      return v[(7 - 32'(i)) * 32 +: 32];
   endfunction

   function automatic word_type round_k(input logic [5:0] i);
      word_type k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ design/sha_front.sv @@
// sha_front: request intake and short queue toward the compression engine
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  q_valid,
   input  logic                  q_pop,
   output sha_pkg::req_item_type q_item
);
   sha_pkg::req_item_type mem_ff [sha_pkg::QDepth];
   logic [sha_pkg::QAw-1:0] wp_ff, rp_ff;
   logic [sha_pkg::QAw:0]   cnt_ff;
   logic push;
   sha_pkg::req_item_type it;

   assign req_tready = (cnt_ff != 3'(sha_pkg::QDepth));
   assign it = '{data_byte: req_tdata, byte_valid: req_tuser, is_last: req_tlast};
   // invalid non-last requests change nothing: drop here
   assign push = req_tvalid && req_tready && (req_tuser || req_tlast);
   assign q_valid = (cnt_ff != '0);
   assign q_item = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= it;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (q_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (push ? 3'd1 : 3'd0) - (q_pop ? 3'd1 : 3'd0);
      end
   end
endmodule

@@ design/sha_back.sv @@
// sha_back: block assembly, padding, 64-round compression and digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  sha_pkg::req_item_type q_item,
   input  logic                  csr_tvalid,
   input  logic                  csr_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COMP = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_OUT  = 3'd3;

   logic [2:0]  st_ff;
   logic        mode_ff;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  fill_ff;
   logic [63:0] cnt_ff;
   logic [5:0]  rnd_ff;
   logic        fin_ff;   // compression is part of finalization
   logic        padded_ff; // 0x80 already placed
   logic        pend_ff;  // padding continues after this block
   logic [2:0]  oidx_ff;
   logic        ovalid_ff;
   logic [31:0] odata_ff;

   logic [31:0] t1, t2, s0, s1, wn, kw;
   logic [7:0]  pb;
   logic        pdo;

   assign kw = sha_pkg::round_k(rnd_ff);
   always_comb begin
      s0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = s1 + w_ff[9] + s0 + w_ff[0];
      t1 = v_ff[7] + (sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
           ^ sha_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + kw + w_ff[0];
      t2 = (sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
           ^ sha_pkg::rotr(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign q_pop = (st_ff == ST_IDLE) && q_valid;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tuser = oidx_ff;
   assign rsp_tlast = (oidx_ff == 3'd7);
   assign pdo = !ovalid_ff || rsp_tready;
   assign pb = padded_ff ? 8'h00 : 8'h80;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; mode_ff <= 1'b0; fill_ff <= '0; cnt_ff <= '0;
         rnd_ff <= '0; fin_ff <= 1'b0; padded_ff <= 1'b0; oidx_ff <= '0;
         pend_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::iv_word(1'b0, 3'(i));
      end else begin
         if (csr_tvalid) begin
            mode_ff <= csr_tdata;
            if (cnt_ff == '0)
               for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::iv_word(csr_tdata, 3'(i));
         end
         unique case (st_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_item.byte_valid) begin
                     w_ff[fill_ff[5:2]] <= (fill_ff[1:0] == 2'd0) ? {q_item.data_byte, 24'd0}
                        : w_ff[fill_ff[5:2]]
                          | ({24'd0, q_item.data_byte} << ((5'd3 - 5'(fill_ff[1:0])) * 5'd8));
                     fill_ff <= fill_ff + 6'd1;
                     cnt_ff <= cnt_ff + 64'd1;
                  end
                  fin_ff <= q_item.is_last;
                  padded_ff <= 1'b0;
                  if (q_item.byte_valid && fill_ff == 6'd63) begin
                     st_ff <= ST_COMP;
                     for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                     rnd_ff <= '0;
                     fin_ff <= 1'b0;
                     pend_ff <= q_item.is_last;
                  end else if (q_item.is_last) st_ff <= ST_PAD;
               end
            end
            ST_PAD: begin
               // one byte per cycle until length position
               if (fill_ff == 6'd56 && padded_ff) begin
                  w_ff[14] <= cnt_ff[60:29];
                  w_ff[15] <= {cnt_ff[28:0], 3'd0};
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  rnd_ff <= '0;
                  fin_ff <= 1'b1;
                  st_ff <= ST_COMP;
               end else begin
                  w_ff[fill_ff[5:2]] <= (fill_ff[1:0] == 2'd0) ? {pb, 24'd0}
                     : w_ff[fill_ff[5:2]]
                       | ({24'd0, pb} << ((5'd3 - 5'(fill_ff[1:0])) * 5'd8));
                  padded_ff <= 1'b1;
                  fill_ff <= fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                     rnd_ff <= '0;
                     fin_ff <= 1'b0;
                     pend_ff <= 1'b1;
                     st_ff <= ST_COMP;
                  end
               end
            end
            ST_COMP: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
               w_ff[15] <= wn;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) begin
                  h_ff[0] <= h_ff[0] + t1 + t2;
                  h_ff[1] <= h_ff[1] + v_ff[0];
                  h_ff[2] <= h_ff[2] + v_ff[1];
                  h_ff[3] <= h_ff[3] + v_ff[2];
                  h_ff[4] <= h_ff[4] + v_ff[3] + t1;
                  h_ff[5] <= h_ff[5] + v_ff[4];
                  h_ff[6] <= h_ff[6] + v_ff[5];
                  h_ff[7] <= h_ff[7] + v_ff[6];
                  if (fin_ff) begin
                     st_ff <= ST_OUT; oidx_ff <= '0;
                  end else if (pend_ff) st_ff <= ST_PAD; // padding still to do
                  else st_ff <= ST_IDLE; // full block, no last
               end
            end
            ST_OUT: begin
               if (pdo) begin
                  if (ovalid_ff && oidx_ff == 3'd7) begin
                     ovalid_ff <= 1'b0;
                     oidx_ff <= '0;
                     fill_ff <= '0; cnt_ff <= '0; padded_ff <= 1'b0; fin_ff <= 1'b0;
                     pend_ff <= 1'b0;
                     for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::iv_word(mode_ff, 3'(i));
                     st_ff <= ST_IDLE;
                  end else begin
                     odata_ff <= h_ff[ovalid_ff ? oidx_ff + 3'd1 : oidx_ff];
                     if (ovalid_ff) oidx_ff <= oidx_ff + 3'd1;
                     ovalid_ff <= 1'b1;
                  end
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ design/sha256_stream_hasher_unit.sv @@
// sha256_stream_hasher_unit: top level of the sha-256 / sha-224 byte stream hasher
// depends on sha_pkg, sha_front, sha_back
//
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tdata=data_byte, tuser=byte_valid, tlast=is_last
// rsp      out  rsp_tvalid/tready    tdata=digest_word, tuser=word_index, tlast=last_word
// csr      in   csr_tvalid/tready    tdata=mode_sha224
//
// one request per cycle into a four-entry queue while it has room; the back takes one byte per idle cycle
// each full 64-byte block is compressed before the back takes further bytes
// finalization: padding up to the length position, one or two 64-round blocks, eight words out
// reset: synchronous, initial values of sha-256
// either side may stall independently through the queue and output register
`timescale 1ns / 1ps
module sha256_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic        csr_tdata
);
   logic q_valid, q_pop;
   sha_pkg::req_item_type q_item;

   assign csr_tready = 1'b1;

   sha_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .req_tlast, .q_valid, .q_pop, .q_item);
   sha_back u_back (.clock, .reset, .q_valid, .q_pop, .q_item, .csr_tvalid, .csr_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast);

`ifndef NO_ASSERTIONS
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd7))) else $error("last flag");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop empty");
`endif
endmodule
